[sv/u8dec_pkg.sv]
// Package for the UTF-8 byte stream decoder: widths and code constants.
// No dependencies; used by utf8_byte_stream_decoder_top.
package u8dec_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;

	// Value emitted for any malformed sequence
	localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;

	// Continuation byte pattern 10xxxxxx (top two bits)
	localparam logic [1:0] CONT_TAG = 2'b10;

	// Number of continuation bytes still owed by an open sequence
	typedef logic [1:0] pend_t;

	localparam pend_t PEND_NONE  = 2'd0;
	localparam pend_t PEND_ONE   = 2'd1;
	localparam pend_t PEND_TWO   = 2'd2;
	localparam pend_t PEND_THREE = 2'd3;

endpackage

[sv/utf8_byte_stream_decoder_top.sv]
// UTF-8 byte stream decoder, top level.
// Depends on u8dec_pkg for widths and constants.

// One byte enters per word on s_axis and at most one code point leaves per word
// on m_axis; a lead byte and its continuation bytes give a single output word
// after the last of them. The block takes one byte per cycle while m_axis does not
// stall: an input register holds the byte, and the decode step against the
// sequence state feeds the output register. A lead byte 0xC0-0xDF, 0xE0-0xEF or
// 0xF0-0xFF always swallows one, two or three following bytes whatever they are;
// a malformed sequence or a stray continuation byte gives U+FFFD. tuser flags
// every word whose value is U+FFFD. No overlong or range check is done. A stall
// on m_axis stops both stages; a byte is still taken while the input register is
// empty.
module utf8_byte_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
	output logic        m_axis_tuser    // [0] bad_sequence
);

	// Input stage
	logic                         valid_s1;
	logic [u8dec_pkg::BYTE_W-1:0] byte_s1;

	// Sequence state
	u8dec_pkg::pend_t           pend_q;
	logic [u8dec_pkg::CP_W-1:0] part_q;
	logic                       bad_q;

	// Output stage
	logic                       valid_s2;
	logic [u8dec_pkg::CP_W-1:0] cp_s2;
	logic                       flag_s2;

	// Decode results
	u8dec_pkg::pend_t           pend_n;
	logic [u8dec_pkg::CP_W-1:0] part_n;
	logic                       bad_n;
	logic                       emit;
	logic [u8dec_pkg::CP_W-1:0] cp_n;
	logic                       seen_bad;
	logic [u8dec_pkg::CP_W-1:0] shifted;

	logic adv;

	// Both stages move when the output register is free or being drained
	assign adv           = !valid_s2 || m_axis_tready;
	assign s_axis_tready = adv || !valid_s1;

	// Decode one byte against the open sequence
	always_comb begin
		pend_n   = pend_q;
		part_n   = part_q;
		bad_n    = bad_q;
		emit     = 1'b0;
		cp_n     = u8dec_pkg::REPL_CHAR;
		seen_bad = bad_q || (byte_s1[7:6] != u8dec_pkg::CONT_TAG);
		shifted  = {part_q[u8dec_pkg::CP_W-7:0], byte_s1[5:0]};
		if (pend_q != u8dec_pkg::PEND_NONE) begin
			pend_n = pend_q - u8dec_pkg::PEND_ONE;
			if (pend_q == u8dec_pkg::PEND_ONE) begin
				emit   = 1'b1;
				cp_n   = seen_bad ? u8dec_pkg::REPL_CHAR : shifted;
				part_n = '0;
				bad_n  = 1'b0;
			end else begin
				part_n = shifted;
				bad_n  = seen_bad;
			end
		end else begin
			case (byte_s1) inside
				[8'h00:8'h7F]: begin
					emit = 1'b1;
					cp_n = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, byte_s1};
				end
				[8'h80:8'hBF]: begin
					emit = 1'b1;
					cp_n = u8dec_pkg::REPL_CHAR;
				end
				[8'hC0:8'hDF]: begin
					bad_n  = 1'b0;
					pend_n = u8dec_pkg::PEND_ONE;
					part_n = {16'd0, byte_s1[4:0]};
				end
				[8'hE0:8'hEF]: begin
					bad_n  = 1'b0;
					pend_n = u8dec_pkg::PEND_TWO;
					part_n = {17'd0, byte_s1[3:0]};
				end
				default: begin
					bad_n  = 1'b0;
					pend_n = u8dec_pkg::PEND_THREE;
					part_n = {18'd0, byte_s1[2:0]};
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Sequence state, updated as the byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= u8dec_pkg::PEND_NONE;
			part_q <= '0;
			bad_q  <= 1'b0;
		end else if (adv && valid_s1) begin
			pend_q <= pend_n;
			part_q <= part_n;
			bad_q  <= bad_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit) begin
			cp_s2   <= cp_n;
			flag_s2 <= (cp_n == u8dec_pkg::REPL_CHAR);
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, cp_s2};
	assign m_axis_tuser  = flag_s2;

endmodule

[tb/tb.sv]
// Testbench for utf8_byte_stream_decoder_top: byte stream in, code points out.
// Depends on u8dec_pkg and the decoder RTL; self-checking against a built-in decoder.
module tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [u8dec_pkg::CP_W-1:0] cp;
		logic                       bad;
	} code_point_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;    // [7:0] data_byte
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [23:0]       m_axis_tdata;    // [20:0] code_point, [23:21] zero
	logic              m_axis_tuser;    // [0] bad_sequence

	// Idle percentages for the current phase
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;

	// Decoder state mirrored by the testbench
	u8dec_pkg::pend_t           seq_left;
	logic [u8dec_pkg::CP_W-1:0] seq_value;
	logic                       seq_broken;

	code_point_t     code_points_due[$];
	int unsigned     bytes_sent;
	int unsigned     mismatches;
	int unsigned     quiet_cycles;

	utf8_byte_stream_decoder_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the decoder by one byte; returns 1 when a code point comes out
	function automatic bit decode_byte(input logic [7:0] b,
			output logic [u8dec_pkg::CP_W-1:0] cp);
		cp = '0;
		if (seq_left != u8dec_pkg::PEND_NONE) begin
			// any byte is swallowed as a continuation; wrong tag only taints it
			if (b[7:6] != u8dec_pkg::CONT_TAG)
				seq_broken = 1'b1;
			seq_value = {seq_value[u8dec_pkg::CP_W-7:0], b[5:0]};
			seq_left  = seq_left - u8dec_pkg::PEND_ONE;
			if (seq_left != u8dec_pkg::PEND_NONE)
				return 1'b0;
			cp = seq_broken ? u8dec_pkg::REPL_CHAR : seq_value;
			seq_value  = '0;
			seq_broken = 1'b0;
			return 1'b1;
		end
		if (!b[7]) begin
			cp = {{(u8dec_pkg::CP_W-8){1'b0}}, b};
			return 1'b1;
		end
		// stray continuation byte
		if (!b[6]) begin
			cp = u8dec_pkg::REPL_CHAR;
			return 1'b1;
		end
		seq_broken = 1'b0;
		if (!b[5]) begin
			seq_left  = u8dec_pkg::PEND_ONE;
			seq_value = {{(u8dec_pkg::CP_W-5){1'b0}}, b[4:0]};
		end else if (!b[4]) begin
			seq_left  = u8dec_pkg::PEND_TWO;
			seq_value = {{(u8dec_pkg::CP_W-4){1'b0}}, b[3:0]};
		end else begin
			seq_left  = u8dec_pkg::PEND_THREE;
			seq_value = {{(u8dec_pkg::CP_W-3){1'b0}}, b[2:0]};
		end
		return 1'b0;
	endfunction

	// Send one byte, idling first at random; queue the code point it yields
	task automatic send_byte(input logic [7:0] b);
		logic [u8dec_pkg::CP_W-1:0] cp;
		code_point_t                due;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		if (decode_byte(b, cp)) begin
			due.cp  = cp;
			due.bad = (cp == u8dec_pkg::REPL_CHAR);
			code_points_due.push_back(due);
		end
	endtask

	// Send n bytes packed in seq, first byte in the highest used position
	task automatic send_seq(input int n, input logic [31:0] seq);
		for (int i = n - 1; i >= 0; i--)
			send_byte(seq[8*i +: 8]);
	endtask

	// Single bytes: ASCII extremes and stray continuation extremes
	task automatic test_single_bytes();
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'hBF);
	endtask

	// Well-formed sequences of two, three and four bytes, overlong and out-of-range included
	task automatic test_well_formed();
		send_seq(2, 32'h0000_C080);  // overlong zero
		send_seq(2, 32'h0000_DFBF);  // 0x7FF
		send_seq(3, 32'h00EF_BFBD);  // encoded U+FFFD, flagged
		send_seq(3, 32'h00ED_A080);  // surrogate, passed through
		send_seq(4, 32'hF48F_BFBF);  // 0x10FFFF
		send_seq(4, 32'hFFBF_BFBF);  // lead 0xF8-0xFF, top bits only
	endtask

	// Malformed sequences: ASCII and lead bytes swallowed as continuations
	task automatic test_malformed();
		send_seq(2, 32'h0000_C341);
		send_seq(2, 32'h0000_C300);
		send_seq(3, 32'h00E1_80FF);
	endtask

	// Mostly well-formed sequences with random payload, plus broken ones and noise
	task automatic test_random_traffic(input int unsigned n_bytes);
		int unsigned     stop_at;
		int unsigned     kind;
		int              len;
		int              bad_pos;
		logic [31:0]     seq;
		logic [7:0]      junk;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			kind = $urandom_range(99);
			if (kind >= 85) begin
				send_byte(8'($urandom));
			end else begin
				len = $urandom_range(1, 4);
				seq = $urandom;
				for (int i = 0; i < len - 1; i++)
					seq[8*i +: 8] = {u8dec_pkg::CONT_TAG, seq[8*i +: 6]};
				case (len)
					1: seq[7:0]   = {1'b0, seq[6:0]};
					2: seq[15:8]  = {3'b110, seq[12:8]};
					3: seq[23:16] = {4'b1110, seq[19:16]};
					default: seq[31:24] = {4'b1111, seq[27:24]};
				endcase
				// break one continuation byte
				if (kind >= 70 && len > 1) begin
					bad_pos = $urandom_range(0, len - 2);
					junk = 8'($urandom);
					if (junk[7:6] == u8dec_pkg::CONT_TAG)
						junk[6] = 1'b1;
					seq[8*bad_pos +: 8] = junk;
				end
				send_seq(len, seq);
			end
		end
	endtask

	// Receiver stalls
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

	// Output checker: every word against the oldest pending code point
	always @(posedge clk) begin
		code_point_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (code_points_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected word: code_point %h bad %b",
						m_axis_tdata, m_axis_tuser);
			end else begin
				due = code_points_due.pop_front();
				if (m_axis_tdata !== {3'b000, due.cp} || m_axis_tuser !== due.bad) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected %h bad %b, got %h bad %b",
							due.cp, due.bad, m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	// Watchdog: ends the run if no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n         <= 1'b0;
		s_axis_tvalid  <= 1'b0;
		s_axis_tdata   <= 8'h00;
		src_idle_pct   = 22;
		sink_stall_pct = 64;
		seq_left       = u8dec_pkg::PEND_NONE;
		seq_value      = '0;
		seq_broken     = 1'b0;
		bytes_sent     = 0;
		mismatches     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_bytes();
		test_well_formed();
		test_malformed();
		test_random_traffic(670);

		src_idle_pct   = 64;
		sink_stall_pct = 22;
		test_random_traffic(670);

		src_idle_pct   = 0;
		sink_stall_pct = 0;
		test_random_traffic(670);

		s_axis_tvalid <= 1'b0;
		while (code_points_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
